// ----- rtl/core/stopwatch_seven_segment_top_assert.svh -----
// Assertion macros for the stopwatch RTL (used by sw7_count), empty when built for synthesis.
`ifndef STOPWATCH_SEVEN_SEGMENT_TOP_ASSERT_SVH
`define STOPWATCH_SEVEN_SEGMENT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on clk, switched off while rst_n is low.
`define SW7_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stopwatch assertion failed");
// Checked on clk at every edge, reset included.
`define SW7_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stopwatch assertion failed");
`else
`define SW7_ASSERT(lbl, prop)
`define SW7_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/core/sw7_pkg.sv -----
// Shared types, constants and the segment table of the stopwatch.
package sw7_pkg;

  localparam int NUM_DIGITS = 6;

  // Digit positions, lowest first.
  localparam int DIG_HUND_ONES = 0;
  localparam int DIG_HUND_TENS = 1;
  localparam int DIG_SEC_ONES  = 2;
  localparam int DIG_SEC_TENS  = 3;
  localparam int DIG_SEC_HUNDS = 4;
  localparam int DIG_SEC_THOUS = 5;

  localparam logic [3:0] BCD_MAX      = 4'd9;
  localparam logic [3:0] BCD_ZERO     = 4'd0;
  localparam logic [3:0] DIVIDE_RESET = 4'd5;
  localparam logic [3:0] KEYS_IDLE    = 4'hF;
  localparam int         KEY_CLEAR    = 1;
  localparam int         KEY_START    = 2;

  localparam logic [7:0] SEG_BLANK   = 8'hFF;
  localparam logic [7:0] SEG_DP_MASK = 8'h7F;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;
  typedef logic [NUM_DIGITS-1:0][7:0] segs_t;

  // Count state after one beat has been applied.
  typedef struct packed {
    digits_t digits;
    logic    running;
  } count_state_t;

  // Active-low segment pattern of one decimal digit.
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/sw7_count.sv -----
// Key edge handling, prescaler and decimal counters of the stopwatch.
`include "stopwatch_seven_segment_top_assert.svh"

module sw7_count
  import sw7_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [3:0]   cfg_wr_data,
  input  logic         step,
  input  logic         tick,
  input  logic [3:0]   keys_level,
  output count_state_t state_nxt
);

  logic [3:0] tick_divide_r;
  logic [3:0] prescale_r;
  logic [3:0] prescale_nxt;
  logic [3:0] prev_keys_r;
  logic       running_r;
  digits_t    digits_r;

  logic [3:0] falling;
  logic       running_mid;
  logic       running_new;
  logic [3:0] prescale_inc;
  logic       hit;
  logic       carry;
  digits_t    digits_new;

  // Keys first: clear, then start/stop; then the prescaler and the BCD count.
  always_comb begin
    falling     = prev_keys_r & ~keys_level;
    running_mid = falling[KEY_CLEAR] ? 1'b0 : running_r;
    running_new = falling[KEY_START] ? ~running_mid : running_mid;
    digits_new  = falling[KEY_CLEAR] ? '0 : digits_r;

    prescale_inc = prescale_r + 4'd1;
    hit          = tick && (prescale_inc >= tick_divide_r);
    if (!tick) begin
      prescale_nxt = prescale_r;
    end else if (hit) begin
      prescale_nxt = '0;
    end else begin
      prescale_nxt = prescale_inc;
    end

    // Ripple the count through the six decimal digits; seconds wrap at 9999.
    carry = hit && running_new;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        if (digits_new[i] >= BCD_MAX) begin
          digits_new[i] = BCD_ZERO;
        end else begin
          digits_new[i] = digits_new[i] + 4'd1;
          carry         = 1'b0;
        end
      end
    end

    state_nxt.digits  = digits_new;
    state_nxt.running = running_new;
  end

  // Divide register; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_divide_r <= DIVIDE_RESET;
    end else if (cfg_wr_en) begin
      tick_divide_r <= cfg_wr_data;
    end
  end

  // Count state moves on when a beat leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= '0;
      prev_keys_r <= KEYS_IDLE;
      running_r   <= 1'b0;
      digits_r    <= '0;
    end else if (step) begin
      prescale_r  <= prescale_nxt;
      prev_keys_r <= keys_level;
      running_r   <= running_new;
      digits_r    <= digits_new;
    end
  end

  // Every stored digit stays a decimal digit.
  `SW7_ASSERT(a_digits_decimal, (digits_r[DIG_HUND_ONES] <= BCD_MAX) && (digits_r[DIG_HUND_TENS] <= BCD_MAX) && (digits_r[DIG_SEC_ONES] <= BCD_MAX) && (digits_r[DIG_SEC_TENS] <= BCD_MAX) && (digits_r[DIG_SEC_HUNDS] <= BCD_MAX) && (digits_r[DIG_SEC_THOUS] <= BCD_MAX))
  // The prescaler is cleared before it can reach the top value.
  `SW7_ASSERT(a_prescale_below_top, prescale_r != 4'hF)
  // A clear press with no start press leaves a stopped, zeroed watch.
  `SW7_ASSERT(a_clear_stops, (step && falling[KEY_CLEAR] && !falling[KEY_START]) |=> (!running_r && (digits_r == '0)))
  // The key history follows the beat just taken.
  `SW7_ASSERT(a_keys_tracked, step |=> (prev_keys_r == $past(keys_level)))
  // Without a beat the count state holds.
  `SW7_ASSERT(a_hold_when_idle, !step |=> ($stable(digits_r) && $stable(running_r) && $stable(prescale_r)))

endmodule

// ----- rtl/core/sw7_seg_encode.sv -----
// Seven-segment encoding with leading-zero blanking and the seconds point.
module sw7_seg_encode
  import sw7_pkg::*;
(
  input  count_state_t count_state,
  output segs_t        segs
);

  digits_t d;
  logic    thous_zero;
  logic    hunds_zero;
  logic    tens_zero;

  // Blanking runs from the thousands digit down and stops at the first nonzero one.
  always_comb begin
    d          = count_state.digits;
    thous_zero = (d[DIG_SEC_THOUS] == BCD_ZERO);
    hunds_zero = thous_zero && (d[DIG_SEC_HUNDS] == BCD_ZERO);
    tens_zero  = hunds_zero && (d[DIG_SEC_TENS] == BCD_ZERO);

    segs[DIG_HUND_ONES] = seg_of(d[DIG_HUND_ONES]);
    segs[DIG_HUND_TENS] = seg_of(d[DIG_HUND_TENS]);
    segs[DIG_SEC_ONES]  = seg_of(d[DIG_SEC_ONES]) & SEG_DP_MASK;
    segs[DIG_SEC_TENS]  = tens_zero  ? SEG_BLANK : seg_of(d[DIG_SEC_TENS]);
    segs[DIG_SEC_HUNDS] = hunds_zero ? SEG_BLANK : seg_of(d[DIG_SEC_HUNDS]);
    segs[DIG_SEC_THOUS] = thous_zero ? SEG_BLANK : seg_of(d[DIG_SEC_THOUS]);
  end

endmodule

// ----- rtl/core/stopwatch_seven_segment_top.sv -----
// A beat accepted into the input register passes through sw7_count and the encoder into the output register.
// Throughput: one beat per cycle while the receiver does not stall, set by the combinational count update in sw7_count.
// The input register frees whenever the output register is empty or being taken.
// Reset (rst_n low, synchronous) empties both registers, stops and zeroes the
// watch, clears the prescaler, marks all keys released and sets tick_divide to 5.
module stopwatch_seven_segment_top
  import sw7_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] tick, [4:1] keys_level, [7:5] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [7:0] digit_hundredths_ones,
                                  // [15:8] digit_hundredths_tens,
                                  // [23:16] digit_seconds_ones,
                                  // [31:24] digit_seconds_tens,
                                  // [39:32] digit_seconds_hundreds,
                                  // [47:40] digit_seconds_thousands,
                                  // [48] is_running, [55:49] zero
);

  logic         in_valid_r;
  logic         tick_r;
  logic [3:0]   keys_r;
  logic         out_valid_r;
  segs_t        segs_r;
  logic         running_out_r;

  logic         advance;
  count_state_t state_nxt;
  segs_t        segs_nxt;

  // A beat leaves the input register when the output register can take it.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tick_r <= in_tdata[0];
      keys_r <= in_tdata[4:1];
    end
  end

  sw7_count u_count (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .step       (advance),
    .tick       (tick_r),
    .keys_level (keys_r),
    .state_nxt  (state_nxt)
  );

  sw7_seg_encode u_seg_encode (
    .count_state(state_nxt),
    .segs       (segs_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      segs_r        <= segs_nxt;
      running_out_r <= state_nxt.running;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, running_out_r, segs_r};

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the stopwatch with seven-segment display.
module testbench;
  import sw7_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] tick, [4:1] keys_level, [7:5] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [7:0] hundredths ones, [15:8] hundredths tens,
                           // [23:16] seconds ones, [31:24] seconds tens,
                           // [39:32] seconds hundreds, [47:40] seconds thousands,
                           // [48] is_running, [55:49] zero

  // Predicts the display for every accepted beat and checks it on the way out.
  class stopwatch_scoreboard;
    logic [3:0]  divide_setting;
    logic [3:0]  prescale;
    logic [3:0]  last_keys;
    logic        running;
    logic [6:0]  hundredths;
    logic [13:0] whole_secs;
    logic [7:0]  seg_code [10];
    logic [55:0] display_q [$];
    int          errors;

    function new();
      seg_code = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
      divide_setting = DIVIDE_RESET;
      prescale = 4'd0;
      last_keys = KEYS_IDLE;
      running = 1'b0;
      hundredths = 7'd0;
      whole_secs = 14'd0;
      errors = 0;
    endfunction

    function void set_divide(input logic [3:0] value);
      divide_setting = value;
    endfunction

    function int pending();
      return display_q.size();
    endfunction

    // Applies one input beat to the predicted state and queues the display it gives.
    function void note_beat(input logic tick, input logic [3:0] keys);
      logic [3:0]  falling;
      logic [3:0]  sec_digit [4];
      logic [7:0]  sec_seg [4];
      logic [55:0] word;
      int          k;
      falling = last_keys & ~keys;
      // The clear key is handled before the start key.
      if (falling[KEY_CLEAR]) begin
        running = 1'b0;
        hundredths = 7'd0;
        whole_secs = 14'd0;
      end
      if (falling[KEY_START]) begin
        running = !running;
      end
      last_keys = keys;

      // The prescaler runs on every tick; only a running watch counts.
      if (tick) begin
        prescale = prescale + 4'd1;
        if (prescale >= divide_setting) begin
          prescale = 4'd0;
          if (running) begin
            if (hundredths == 7'd99) begin
              hundredths = 7'd0;
              whole_secs = (whole_secs == 14'd9999) ? 14'd0 : whole_secs + 14'd1;
            end else begin
              hundredths = hundredths + 7'd1;
            end
          end
        end
      end

      sec_digit[0] = 4'(whole_secs % 10);
      sec_digit[1] = 4'((whole_secs / 10) % 10);
      sec_digit[2] = 4'((whole_secs / 100) % 10);
      sec_digit[3] = 4'((whole_secs / 1000) % 10);

      // Leading zeros are blanked from the thousands down to the tens digit.
      k = 3;
      while (k >= 1 && sec_digit[k] == 4'd0) begin
        sec_seg[k] = SEG_BLANK;
        k--;
      end
      while (k >= 0) begin
        sec_seg[k] = seg_code[sec_digit[k]];
        k--;
      end
      sec_seg[0] = sec_seg[0] & SEG_DP_MASK;

      word = '0;
      word[DIG_HUND_ONES*8 +: 8] = seg_code[hundredths % 10];
      word[DIG_HUND_TENS*8 +: 8] = seg_code[hundredths / 10];
      word[DIG_SEC_ONES*8 +: 8]  = sec_seg[0];
      word[DIG_SEC_TENS*8 +: 8]  = sec_seg[1];
      word[DIG_SEC_HUNDS*8 +: 8] = sec_seg[2];
      word[DIG_SEC_THOUS*8 +: 8] = sec_seg[3];
      word[NUM_DIGITS*8]         = running;
      display_q.push_back(word);
    endfunction

    // Compares one display beat with the oldest prediction, digit by digit, then is_running.
    function void check_result(input logic [55:0] got);
      logic [55:0] want;
      int          d;
      if (display_q.size() == 0) begin
        errors++;
        if (errors < 50) begin
          $display("%0t: display beat with nothing predicted, got %h", $time, got);
        end
        return;
      end
      want = display_q.pop_front();
      for (d = 0; d < NUM_DIGITS; d++) begin
        if (got[d*8 +: 8] !== want[d*8 +: 8]) begin
          errors++;
          if (errors < 50) begin
            $display("%0t: digit %0d expected %02h actual %02h",
                     $time, d, want[d*8 +: 8], got[d*8 +: 8]);
          end
        end
      end
      if (got[NUM_DIGITS*8] !== want[NUM_DIGITS*8]) begin
        errors++;
        if (errors < 50) begin
          $display("%0t: is_running expected %b actual %b",
                   $time, want[NUM_DIGITS*8], got[NUM_DIGITS*8]);
        end
      end
    endfunction
  endclass

  stopwatch_scoreboard sb = new();

  bit steady = 1'b0;        // no idling on either side while set
  bit hold_request = 1'b0;  // asks the receiver for one long hold-off

  // Opening sequence, each entry {keys_level, tick}.
  logic [4:0] opening_seq [21] = '{
    {4'hF, 1'b0}, {4'hF, 1'b1}, {4'hB, 1'b1}, {4'hF, 1'b1}, {4'hF, 1'b1},
    {4'hF, 1'b1}, {4'hF, 1'b1}, {4'hE, 1'b1}, {4'h7, 1'b1}, {4'hF, 1'b1},
    {4'hD, 1'b0}, {4'hF, 1'b1}, {4'h9, 1'b1}, {4'hF, 1'b1}, {4'hF, 1'b1},
    {4'h0, 1'b0}, {4'h0, 1'b1}, {4'hF, 1'b0}, {4'hB, 1'b0}, {4'hB, 1'b1},
    {4'hF, 1'b1}
  };

  // Divide settings of the random phases, extremes and the zero value among them.
  logic [3:0] divide_plan [8] = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd9, 4'd2, 4'd15, 4'd1};

  stopwatch_seven_segment_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one beat after an optional gap and waits for it to be taken.
  task automatic send_beat(input logic tick, input logic [3:0] keys, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, keys, tick};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(tick, keys);
  endtask

  // Writes tick_divide once every predicted display has come out.
  task automatic write_divide(input logic [3:0] value);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_divide(value);
  endtask

  // Receiver: takes display beats, with random stalls and one long hold-off.
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        stall_left = 0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = pick_idle();
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Stimulus: opening sequence, then random phases, one per divide setting.
  initial begin : stimulus
    int         phase;
    int         n;
    int         burst;
    int         r;
    logic [3:0] keys;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_seq[i]) begin
      send_beat(opening_seq[i][0], opening_seq[i][4:1], pick_idle());
    end

    keys = KEYS_IDLE;
    for (phase = 0; phase < 8; phase++) begin
      write_divide(divide_plan[phase]);
      steady = (phase == 3);
      burst = 0;
      for (n = 0; n < 150; n++) begin
        // One long hold-off while the sender keeps offering beats.
        if (phase == 1 && n == 40) begin
          hold_request = 1'b1;
          burst = 30;
        end
        // Mostly released keys, with occasional presses and held levels.
        r = $urandom_range(0, 99);
        if (r < 86) begin
          keys = KEYS_IDLE;
        end else if (r < 90) begin
          keys = KEYS_IDLE;
          keys[KEY_START] = 1'b0;
        end else if (r < 91) begin
          keys = KEYS_IDLE;
          keys[KEY_CLEAR] = 1'b0;
        end else if (r < 92) begin
          keys = KEYS_IDLE;
          keys[KEY_CLEAR] = 1'b0;
          keys[KEY_START] = 1'b0;
        end else if (r < 96) begin
          keys = 4'($urandom_range(0, 15));
        end
        send_beat($urandom_range(0, 99) < 80, keys,
                  (steady || burst > 0) ? 0 : pick_idle());
        if (burst > 0) burst--;
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sw7_pkg.sv
rtl/core/sw7_count.sv
rtl/core/sw7_seg_encode.sv
rtl/core/stopwatch_seven_segment_top.sv
bench/testbench.sv
